// ===== rtl/tcwrs_pkg.sv =====
package tcwrs_pkg;

  localparam int CHAR_W        = 7;
  localparam int KEY_W         = 3 * CHAR_W;
  localparam int DIGIT_W       = 4;
  localparam int RADIX         = 1 << DIGIT_W;
  localparam int NUM_PASSES    = (KEY_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PASS_W        = $clog2(NUM_PASSES);
  localparam int PAD_W         = NUM_PASSES * DIGIT_W - KEY_W;
  localparam int TDATA_W       = ((KEY_W + 7) / 8) * 8;
  localparam int MAX_WORDS_DEF = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_COUNT,
    ST_PREFIX,
    ST_SCATTER,
    ST_EMIT_RD,
    ST_EMIT_CAP,
    ST_EMIT_WAIT
  } state_e;

  typedef struct packed {
    logic key_we;
    logic rd_en;
    logic src_b;
    logic clr_cnt;
    logic cnt_inc;
    logic pfx_step;
    logic scat_we;
    logic emit_load;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic out_taken;
  } sts_t;

endpackage

// ===== rtl/tcwrs_ctrl.sv =====
module tcwrs_ctrl #(
  parameter int MAX_WORDS = tcwrs_pkg::MAX_WORDS_DEF,
  parameter int AW        = $clog2(MAX_WORDS),
  parameter int CW        = $clog2(MAX_WORDS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  input  logic                            s_last_i,
  output logic                            s_ready_o,
  input  tcwrs_pkg::sts_t                 sts_i,
  output tcwrs_pkg::cmd_t                 cmd_o,
  output logic [AW-1:0]                   addr_o,
  output logic [tcwrs_pkg::PASS_W-1:0]    pass_o,
  output logic [tcwrs_pkg::DIGIT_W-1:0]   dig_o
);
  import tcwrs_pkg::*;

  localparam logic EmitFromB = (NUM_PASSES % 2) == 1;

  state_e               state_q, state_d;
  logic [CW-1:0]        wc_q, wc_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [DIGIT_W-1:0]   dig_q, dig_d;
  logic [PASS_W-1:0]    pass_q, pass_d;
  logic                 dv_q, dv_d;
  logic                 accept;
  logic                 rd_issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      wc_q    <= '0;
      idx_q   <= '0;
      dig_q   <= '0;
      pass_q  <= '0;
      dv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wc_q    <= wc_d;
      idx_q   <= idx_d;
      dig_q   <= dig_d;
      pass_q  <= pass_d;
      dv_q    <= dv_d;
    end
  end

  assign s_ready_o = (state_q == ST_LOAD);
  assign accept    = s_valid_i && s_ready_o;
  assign rd_issue  = (idx_q != wc_q);
  assign pass_o    = pass_q;
  assign dig_o     = dig_q;

  always_comb begin
    state_d = state_q;
    wc_d    = wc_q;
    idx_d   = idx_q;
    dig_d   = dig_q;
    pass_d  = pass_q;
    dv_d    = 1'b0;
    cmd_o   = '0;
    cmd_o.src_b = pass_q[0];
    addr_o  = idx_q[AW-1:0];

    case (state_q)
      ST_LOAD: begin
        addr_o = wc_q[AW-1:0];
        if (accept) begin
          cmd_o.key_we = 1'b1;
          wc_d = wc_q + CW'(1);
          // a full store closes the set even without the last flag
          if (s_last_i || (wc_q + CW'(1) == CW'(MAX_WORDS))) begin
            pass_d  = '0;
            state_d = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_cnt = 1'b1;
        idx_d   = '0;
        state_d = ST_COUNT;
      end
      ST_COUNT: begin
        cmd_o.rd_en   = rd_issue;
        cmd_o.cnt_inc = dv_q;
        dv_d = rd_issue;
        if (rd_issue) begin
          idx_d = idx_q + CW'(1);
        end else if (!dv_q) begin
          dig_d   = '0;
          state_d = ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        cmd_o.pfx_step = 1'b1;
        dig_d = dig_q + DIGIT_W'(1);
        if (dig_q == DIGIT_W'(RADIX - 1)) begin
          idx_d   = '0;
          state_d = ST_SCATTER;
        end
      end
      ST_SCATTER: begin
        cmd_o.rd_en   = rd_issue;
        cmd_o.scat_we = dv_q;
        dv_d = rd_issue;
        if (rd_issue) begin
          idx_d = idx_q + CW'(1);
        end else if (!dv_q) begin
          idx_d = '0;
          if (pass_q == PASS_W'(NUM_PASSES - 1)) begin
            state_d = ST_EMIT_RD;
          end else begin
            pass_d  = pass_q + PASS_W'(1);
            state_d = ST_CLEAR;
          end
        end
      end
      ST_EMIT_RD: begin
        cmd_o.src_b = EmitFromB;
        cmd_o.rd_en = 1'b1;
        state_d = ST_EMIT_CAP;
      end
      ST_EMIT_CAP: begin
        cmd_o.src_b     = EmitFromB;
        cmd_o.emit_load = 1'b1;
        cmd_o.emit_last = (idx_q == wc_q - CW'(1));
        state_d = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        cmd_o.src_b = EmitFromB;
        if (sts_i.out_taken) begin
          if (idx_q == wc_q - CW'(1)) begin
            wc_d    = '0;
            idx_d   = '0;
            state_d = ST_LOAD;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/tcwrs_dpath.sv =====
module tcwrs_dpath #(
  parameter int MAX_WORDS = tcwrs_pkg::MAX_WORDS_DEF,
  parameter int AW        = $clog2(MAX_WORDS),
  parameter int CW        = $clog2(MAX_WORDS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tcwrs_pkg::cmd_t                 cmd_i,
  output tcwrs_pkg::sts_t                 sts_o,
  input  logic [AW-1:0]                   addr_i,
  input  logic [tcwrs_pkg::PASS_W-1:0]    pass_i,
  input  logic [tcwrs_pkg::DIGIT_W-1:0]   dig_i,
  input  logic [tcwrs_pkg::TDATA_W-1:0]   in_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            out_last_o,
  output logic [tcwrs_pkg::TDATA_W-1:0]   out_data_o
);
  import tcwrs_pkg::*;

  logic [KEY_W-1:0]   mem_a [MAX_WORDS];
  logic [KEY_W-1:0]   mem_b [MAX_WORDS];
  logic [KEY_W-1:0]   rd_a_q, rd_b_q;
  logic [CW-1:0]      cnt_q [RADIX];
  logic [CW-1:0]      acc_q;
  logic [KEY_W-1:0]   in_key;
  logic [KEY_W-1:0]   rd_key;
  logic [KEY_W-1:0]   wdata;
  logic [AW-1:0]      waddr;
  logic               a_we, b_we;
  logic [NUM_PASSES*DIGIT_W-1:0] key_pad;
  logic [DIGIT_W-1:0] digit;
  logic [DIGIT_W-1:0] cidx;
  logic [CW-1:0]      cval;
  logic               out_valid_q, out_last_q;
  logic [KEY_W-1:0]   out_key_q;

  // first character goes to the top of the key
  assign in_key = {in_data_i[0 +: CHAR_W], in_data_i[CHAR_W +: CHAR_W],
                   in_data_i[2*CHAR_W +: CHAR_W]};

  assign rd_key  = cmd_i.src_b ? rd_b_q : rd_a_q;
  assign key_pad = {{PAD_W{1'b0}}, rd_key};
  assign digit   = key_pad[pass_i*DIGIT_W +: DIGIT_W];
  assign cidx    = cmd_i.pfx_step ? dig_i : digit;
  assign cval    = cnt_q[cidx];

  // scatter writes into the buffer that is not the source of this pass
  assign a_we  = cmd_i.key_we || (cmd_i.scat_we && cmd_i.src_b);
  assign b_we  = cmd_i.scat_we && !cmd_i.src_b;
  assign wdata = cmd_i.key_we ? in_key : rd_key;
  assign waddr = cmd_i.key_we ? addr_i : cval[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mem_a[waddr] <= wdata;
    end
    if (b_we) begin
      mem_b[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem_a[addr_i];
      rd_b_q <= mem_b[addr_i];
    end
  end

  // counts become start positions after the prefix sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RADIX; i++) begin
        cnt_q[i] <= '0;
      end
      acc_q <= '0;
    end else if (cmd_i.clr_cnt) begin
      for (int i = 0; i < RADIX; i++) begin
        cnt_q[i] <= '0;
      end
      acc_q <= '0;
    end else if (cmd_i.cnt_inc || cmd_i.scat_we) begin
      cnt_q[cidx] <= cval + CW'(1);
    end else if (cmd_i.pfx_step) begin
      cnt_q[cidx] <= acc_q;
      acc_q       <= acc_q + cval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
      out_last_q  <= cmd_i.emit_last;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_key_q <= rd_key;
    end
  end

  assign sts_o.out_taken = out_valid_q && out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_last_o      = out_last_q;
  assign out_data_o      = {{(TDATA_W - KEY_W){1'b0}}, out_key_q[0 +: CHAR_W],
                            out_key_q[CHAR_W +: CHAR_W], out_key_q[2*CHAR_W +: CHAR_W]};

endmodule

// ===== rtl/three_char_word_radix_sort.sv =====
// loading: one word per cycle while tvalid is high; after the last word, 6 digit passes
// run over the n stored words, each a clear, a counting read of every word, a 16-step
// prefix sweep of the digit counters and a scattering read, all through the single read
// port of the key buffers
// output: each sorted word is read, captured and held until taken before the next is read
// reset: asynchronous active low, clears control, digit counters and output valid; buffers need no clearing
module three_char_word_radix_sort #(
  parameter int MAX_WORDS = tcwrs_pkg::MAX_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // char_first [6:0], char_second [13:7], char_third [20:14], zero [23:21]
  input  logic [tcwrs_pkg::TDATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_first [6:0], out_second [13:7], out_third [20:14], zero [23:21]
  output logic [tcwrs_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);
  import tcwrs_pkg::*;

  localparam int AW = $clog2(MAX_WORDS);
  localparam int CW = $clog2(MAX_WORDS + 1);

  cmd_t                cmd;
  sts_t                sts;
  logic [AW-1:0]       addr;
  logic [PASS_W-1:0]   pass;
  logic [DIGIT_W-1:0]  dig;

  tcwrs_ctrl #(
    .MAX_WORDS (MAX_WORDS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .addr_o    (addr),
    .pass_o    (pass),
    .dig_o     (dig)
  );

  tcwrs_dpath #(
    .MAX_WORDS (MAX_WORDS),
    .AW        (AW),
    .CW        (CW)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .addr_i      (addr),
    .pass_i      (pass),
    .dig_i       (dig),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_last_o  (m_axis_tlast),
    .out_data_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_no_load_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a sorted word is pending");

  a_last_closes_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("loading continued after the last word");

  a_valid_from_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.emit_load))
    else $error("output valid without a capture");

  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.key_we && cmd.scat_we))
    else $error("load and scatter write in the same cycle");
`endif

endmodule
